FILE: src/ctsg_pkg.sv
package ctsg_pkg;

    // default coordinate width
    localparam int CTSG_COORD_WIDTH = 24;

    // fixed field widths
    localparam int HEAD_WIDTH  = 16;
    localparam int SPEED_WIDTH = 16;
    localparam int LIMIT_WIDTH = 15;

endpackage

FILE: src/ctsg_sqrt.sv
module ctsg_sqrt #(
    parameter int R  = 25,
    parameter int PW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_v,
    input  logic [2*R-1:0]  rad,
    input  logic [PW-1:0]   in_pay,
    output logic            out_v,
    output logic [R-1:0]    root,
    output logic [PW-1:0]   out_pay
);

    // one root bit per stage, index 0 is the input side
    logic            v_w    [R+1];
    logic [R-1:0]    root_w [R+1];
    logic [R+1:0]    rem_w  [R+1];
    logic [2*R-1:0]  rad_w  [R+1];
    logic [PW-1:0]   pay_w  [R+1];

    assign v_w[0]    = in_v;
    assign root_w[0] = '0;
    assign rem_w[0]  = '0;
    assign rad_w[0]  = rad;
    assign pay_w[0]  = in_pay;

    genvar k;
    generate
        for (k = 0; k < R; k++) begin : g_stage
            logic            v_reg;
            logic [R-1:0]    root_reg;
            logic [R+1:0]    rem_reg;
            logic [2*R-1:0]  rad_reg;
            logic [PW-1:0]   pay_reg;
            logic [R+1:0]    remc;
            logic [R+1:0]    trial;
            logic            ge;

            // bring down the next two radicand bits and try a one
            assign remc  = {rem_w[k][R-1:0], rad_w[k][2*R-1:2*R-2]};
            assign trial = {root_w[k], 2'b01};
            assign ge    = remc >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else if (en)
                begin
                    v_reg <= v_w[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg <= {root_w[k][R-2:0], ge};
                    rem_reg  <= ge ? remc - trial : remc;
                    rad_reg  <= {rad_w[k][2*R-3:0], 2'b00};
                    pay_reg  <= pay_w[k];
                end
            end

            assign v_w[k+1]    = v_reg;
            assign root_w[k+1] = root_reg;
            assign rem_w[k+1]  = rem_reg;
            assign rad_w[k+1]  = rad_reg;
            assign pay_w[k+1]  = pay_reg;
        end
    endgenerate

    assign out_v   = v_w[R];
    assign root    = root_w[R];
    assign out_pay = pay_w[R];

endmodule

FILE: src/ctsg_div.sv
module ctsg_div #(
    parameter int W  = 24,
    parameter int PW = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       en,
    input  logic                                       in_v,
    input  logic [W:0]                                 divisor,
    input  logic [2:0][W+ctsg_pkg::SPEED_WIDTH-1:0]    num,
    input  logic [PW-1:0]                              in_pay,
    output logic                                       out_v,
    output logic [2:0][W-1:0]                          quot,
    output logic [PW-1:0]                              out_pay
);

    import ctsg_pkg::*;

    localparam int R = W + 1;

    // one quotient bit per stage for all three lanes
    logic                  v_w    [W+1];
    logic [R-1:0]          dist_w [W+1];
    logic [2:0][R:0]       rem_w  [W+1];
    logic [2:0][W-1:0]     low_w  [W+1];
    logic [2:0][W-1:0]     q_w    [W+1];
    logic [PW-1:0]         pay_w  [W+1];

    assign v_w[0]    = in_v;
    assign dist_w[0] = divisor;
    assign pay_w[0]  = in_pay;

    // quotient stays below 2^W, so the top bits start the remainder
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_w[0][i] = (R+1)'(num[i] >> W);
            low_w[0][i] = num[i][W-1:0];
            q_w[0][i]   = '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stage
            logic              v_reg;
            logic [R-1:0]      dist_reg;
            logic [2:0][R:0]   rem_reg;
            logic [2:0][W-1:0] low_reg;
            logic [2:0][W-1:0] q_reg;
            logic [PW-1:0]     pay_reg;
            logic [2:0][R:0]   rem_next;
            logic [2:0][W-1:0] q_next;

            // shift in one numerator bit and subtract where it fits
            always_comb
            begin
                logic [R:0] remc;
                logic       ge;
                for (int i = 0; i < 3; i++)
                begin
                    remc        = {rem_w[k][i][R-1:0], low_w[k][i][W-1]};
                    ge          = remc >= {1'b0, dist_w[k]};
                    rem_next[i] = ge ? remc - {1'b0, dist_w[k]} : remc;
                    q_next[i]   = {q_w[k][i][W-2:0], ge};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else if (en)
                begin
                    v_reg <= v_w[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dist_reg <= dist_w[k];
                    rem_reg  <= rem_next;
                    q_reg    <= q_next;
                    pay_reg  <= pay_w[k];
                    for (int i = 0; i < 3; i++)
                    begin
                        low_reg[i] <= {low_w[k][i][W-2:0], 1'b0};
                    end
                end
            end

            assign v_w[k+1]    = v_reg;
            assign dist_w[k+1] = dist_reg;
            assign rem_w[k+1]  = rem_reg;
            assign low_w[k+1]  = low_reg;
            assign q_w[k+1]    = q_reg;
            assign pay_w[k+1]  = pay_reg;
        end
    endgenerate

    assign out_v   = v_w[W];
    assign quot    = q_w[W];
    assign out_pay = pay_w[W];

endmodule

FILE: src/clamped_step_toward_target_3d_top.sv
// Moves a 3D pose one step toward a target pose.
// Input channel in_valid/in_ready carries one item: current pose, goal pose,
// speed, heading error and turn limit. Output channel out_valid/out_ready
// carries the new pose and the arrived flag, one result per item, in order.
// Throughput: one item per cycle while the output is not stalled, fully pipelined.
// Pipeline stages, in order: input stage, squares, sum, one square-root
// stage per root bit (COORD_WIDTH+1), speed*delta products, one divider
// stage per quotient bit (COORD_WIDTH), output register.
// All stages advance together; when the receiver holds out_ready low with a
// result waiting, the whole pipeline holds and in_ready drops, so nothing is
// lost or repeated. Empty slots move on freely while the output is free.
// Reset clears all valid bits; the pipeline is empty after reset and is
// ready to take an item once reset is released.
module clamped_step_toward_target_3d_top #(
    parameter int COORD_WIDTH = ctsg_pkg::CTSG_COORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        cur_x,
    input  logic signed [COORD_WIDTH-1:0]        cur_y,
    input  logic signed [COORD_WIDTH-1:0]        cur_z,
    input  logic signed [ctsg_pkg::HEAD_WIDTH-1:0] cur_heading,
    input  logic signed [COORD_WIDTH-1:0]        goal_x,
    input  logic signed [COORD_WIDTH-1:0]        goal_y,
    input  logic signed [COORD_WIDTH-1:0]        goal_z,
    input  logic signed [ctsg_pkg::HEAD_WIDTH-1:0] goal_heading,
    input  logic [ctsg_pkg::SPEED_WIDTH-1:0]     speed,
    input  logic signed [ctsg_pkg::HEAD_WIDTH-1:0] heading_error,
    input  logic [ctsg_pkg::LIMIT_WIDTH-1:0]     turn_limit,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [COORD_WIDTH-1:0]        new_x,
    output logic signed [COORD_WIDTH-1:0]        new_y,
    output logic signed [COORD_WIDTH-1:0]        new_z,
    output logic signed [ctsg_pkg::HEAD_WIDTH-1:0] new_heading,
    output logic                                 arrived
);

    import ctsg_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int R   = W + 1;
    localparam int HW  = HEAD_WIDTH;
    localparam int SW  = SPEED_WIDTH;
    localparam int NW  = W + SW;
    // sqrt payload: cur, goal, mag, neg, speed, heading, heading match
    localparam int PW1 = 9 * W + 3 + SW + HW + 1;
    localparam int O1_NH  = 1;
    localparam int O1_SP  = O1_NH + HW;
    localparam int O1_NEG = O1_SP + SW;
    localparam int O1_MAG = O1_NEG + 3;
    localparam int O1_GL  = O1_MAG + 3 * W;
    localparam int O1_CR  = O1_GL + 3 * W;
    // divider payload: cur, goal, neg, move flag, heading, heading match
    localparam int PW2 = 6 * W + 3 + 1 + HW + 1;
    localparam int O2_NH  = 1;
    localparam int O2_MV  = O2_NH + HW;
    localparam int O2_NEG = O2_MV + 1;
    localparam int O2_GL  = O2_NEG + 3;
    localparam int O2_CR  = O2_GL + 3 * W;

    logic en;
    logic out_valid_reg;

    // the whole pipeline moves unless a result is stuck at the output
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: deltas, magnitudes, heading
    logic [W-1:0]  cur_in  [3];
    logic [W-1:0]  goal_in [3];
    logic [W-1:0]  mag_c   [3];
    logic [2:0]    neg_c;
    logic [HW-1:0] nh_c;
    logic          hm_c;

    assign cur_in[0]  = cur_x;
    assign cur_in[1]  = cur_y;
    assign cur_in[2]  = cur_z;
    assign goal_in[0] = goal_x;
    assign goal_in[1] = goal_y;
    assign goal_in[2] = goal_z;

    always_comb
    begin
        logic [W:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d        = {goal_in[i][W-1], goal_in[i]} - {cur_in[i][W-1], cur_in[i]};
            neg_c[i] = d[W];
            mag_c[i] = d[W] ? W'(-d) : d[W-1:0];
        end
    end

    // heading: snap inside the limit, otherwise turn by the limit
    always_comb
    begin
        logic signed [HW:0] err_e;
        logic signed [HW:0] lim_e;
        logic [HW-1:0]      lim_h;
        err_e = {heading_error[HW-1], heading_error};
        lim_e = {2'b00, turn_limit};
        lim_h = {1'b0, turn_limit};
        if (err_e <= lim_e)
        begin
            if (err_e >= -lim_e)
            begin
                nh_c = goal_heading;
            end
            else
            begin
                nh_c = cur_heading - lim_h;
            end
        end
        else
        begin
            nh_c = cur_heading + lim_h;
        end
        hm_c = nh_c == goal_heading;
    end

    logic          v1_reg;
    logic [W-1:0]  cur1_reg  [3];
    logic [W-1:0]  goal1_reg [3];
    logic [W-1:0]  mag1_reg  [3];
    logic [2:0]    neg1_reg;
    logic [SW-1:0] sp1_reg;
    logic [HW-1:0] nh1_reg;
    logic          hm1_reg;

    // stage 2: squares
    logic            v2_reg;
    logic [2*W-1:0]  sq2_reg [3];
    logic [PW1-1:0]  pay2_reg;

    // stage 3: sum of squares
    logic              v3_reg;
    logic [2*W+1:0]    sum3_reg;
    logic [PW1-1:0]    pay3_reg;

    logic [PW1-1:0]    pay1_c;

    always_comb
    begin
        pay1_c        = '0;
        pay1_c[0]     = hm1_reg;
        pay1_c[O1_NH +: HW]  = nh1_reg;
        pay1_c[O1_SP +: SW]  = sp1_reg;
        pay1_c[O1_NEG +: 3]  = neg1_reg;
        for (int i = 0; i < 3; i++)
        begin
            pay1_c[O1_MAG + i * W +: W] = mag1_reg[i];
            pay1_c[O1_GL + i * W +: W]  = goal1_reg[i];
            pay1_c[O1_CR + i * W +: W]  = cur1_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cur1_reg[i]  <= cur_in[i];
                goal1_reg[i] <= goal_in[i];
                mag1_reg[i]  <= mag_c[i];
                sq2_reg[i]   <= (2*W)'(mag1_reg[i]) * (2*W)'(mag1_reg[i]);
            end
            neg1_reg <= neg_c;
            sp1_reg  <= speed;
            nh1_reg  <= nh_c;
            hm1_reg  <= hm_c;
            pay2_reg <= pay1_c;
            sum3_reg <= (2*W+2)'(sq2_reg[0]) + (2*W+2)'(sq2_reg[1])
                        + (2*W+2)'(sq2_reg[2]);
            pay3_reg <= pay2_reg;
        end
    end

    // square root, one bit per stage
    logic           v4_w;
    logic [R-1:0]   dist_w;
    logic [PW1-1:0] pay4_w;

    ctsg_sqrt #(
        .R  (R),
        .PW (PW1)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (v3_reg),
        .rad     (sum3_reg),
        .in_pay  (pay3_reg),
        .out_v   (v4_w),
        .root    (dist_w),
        .out_pay (pay4_w)
    );

    // stage 5: speed times magnitude, move decision
    logic                 v5_reg;
    logic [R-1:0]         dist5_reg;
    logic [2:0][NW-1:0]   num5_reg;
    logic [PW2-1:0]       pay5_reg;
    logic [SW-1:0]        sp4;
    logic [PW2-1:0]       pay5_c;

    assign sp4 = pay4_w[O1_SP +: SW];

    always_comb
    begin
        pay5_c             = '0;
        pay5_c[0]          = pay4_w[0];
        pay5_c[O2_NH +: HW] = pay4_w[O1_NH +: HW];
        pay5_c[O2_MV]      = R'(sp4) < dist_w;
        pay5_c[O2_NEG +: 3] = pay4_w[O1_NEG +: 3];
        pay5_c[O2_GL +: 3 * W] = pay4_w[O1_GL +: 3 * W];
        pay5_c[O2_CR +: 3 * W] = pay4_w[O1_CR +: 3 * W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist5_reg <= dist_w;
            pay5_reg  <= pay5_c;
            for (int i = 0; i < 3; i++)
            begin
                num5_reg[i] <= NW'(sp4) * NW'(pay4_w[O1_MAG + i * W +: W]);
            end
        end
    end

    // division by the distance, one quotient bit per stage
    logic               v6_w;
    logic [2:0][W-1:0]  quot_w;
    logic [PW2-1:0]     pay6_w;

    ctsg_div #(
        .W  (W),
        .PW (PW2)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (v5_reg),
        .divisor (dist5_reg),
        .num     (num5_reg),
        .in_pay  (pay5_reg),
        .out_v   (v6_w),
        .quot    (quot_w),
        .out_pay (pay6_w)
    );

    // output stage: apply the step or snap to the goal
    logic [W-1:0]  res_c [3];
    logic          pos_eq_c;
    logic [W-1:0]  res_reg [3];
    logic [HW-1:0] nh_reg;
    logic          arr_reg;

    always_comb
    begin
        logic [W-1:0] cur_v;
        logic [W-1:0] goal_v;
        pos_eq_c = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cur_v  = pay6_w[O2_CR + i * W +: W];
            goal_v = pay6_w[O2_GL + i * W +: W];
            if (pay6_w[O2_MV])
            begin
                res_c[i] = pay6_w[O2_NEG + i] ? cur_v - quot_w[i] : cur_v + quot_w[i];
            end
            else
            begin
                res_c[i] = goal_v;
            end
            if (res_c[i] != goal_v)
            begin
                pos_eq_c = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v6_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= res_c[i];
            end
            nh_reg  <= pay6_w[O2_NH +: HW];
            arr_reg <= pos_eq_c && pay6_w[0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_x       = res_reg[0];
    assign new_y       = res_reg[1];
    assign new_z       = res_reg[2];
    assign new_heading = nh_reg;
    assign arrived     = arr_reg;

endmodule
